### rtl/core/assert_macros.svh
// Assertion helpers: every check is clocked on clk and muted while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define HPDS_ASSERT_NOW(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Implication checked in the next cycle.
`define HPDS_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/hpds_pkg.sv
package hpds_pkg;

    localparam int unsigned TIMER_W    = 32;
    localparam int unsigned CUR_W      = 10;
    localparam int unsigned ELAPSED_W  = 10;
    localparam int unsigned STATE_W    = 4;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned IN_DATA_W  = 24;
    localparam int unsigned OUT_DATA_W = 16;

    localparam logic [STATE_W-1:0] ST_UP           = 4'd0;
    localparam logic [STATE_W-1:0] ST_SOFT_HALT    = 4'd1;
    localparam logic [STATE_W-1:0] ST_HALT         = 4'd2;
    localparam logic [STATE_W-1:0] ST_CUR_CHECK    = 4'd3;
    localparam logic [STATE_W-1:0] ST_TIMEOUT      = 4'd4;
    localparam logic [STATE_W-1:0] ST_AT_HALT_CUR  = 4'd5;
    localparam logic [STATE_W-1:0] ST_DELAY        = 4'd6;
    localparam logic [STATE_W-1:0] ST_SETTLE       = 4'd7;
    localparam logic [STATE_W-1:0] ST_DOWN         = 4'd8;
    localparam logic [STATE_W-1:0] ST_RESTART      = 4'd9;
    localparam logic [STATE_W-1:0] ST_RESTART_DLY  = 4'd10;
    localparam logic [STATE_W-1:0] ST_FAIL         = 4'd11;

    localparam logic [TIMER_W-1:0] BUTTON_HOLD_MS = 32'd2000;
    localparam logic [TIMER_W-1:0] HALT_PULSE_MS  = 32'd200;
    localparam logic [TIMER_W-1:0] LOCKOUT_MS     = 32'd60000;

    localparam logic [CFG_IDX_W-1:0] CFG_HALT_CURRENT_LIMIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALT_TIMEOUT_MS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POST_HALT_DELAY_MS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TIME_MS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTIFY_ENABLE      = 3'd4;

    localparam logic [CUR_W-1:0]   RST_HALT_CURRENT_LIMIT = 10'd100;
    localparam logic [TIMER_W-1:0] RST_HALT_TIMEOUT_MS    = 32'd180000;
    localparam logic [TIMER_W-1:0] RST_POST_HALT_DELAY_MS = 32'd1000;
    localparam logic [TIMER_W-1:0] RST_SETTLE_TIME_MS     = 32'd1000;

    typedef struct packed {
        logic [CUR_W-1:0]   halt_current_limit;
        logic [TIMER_W-1:0] halt_timeout_ms;
        logic [TIMER_W-1:0] post_halt_delay_ms;
        logic [TIMER_W-1:0] settle_time_ms;
        logic               notify_enable;
    } cfg_t;

    typedef struct packed {
        logic               skip_step;
        logic               soft_halt_request;
        logic [CUR_W-1:0]   supply_current;
        logic               button_low;
        logic [ELAPSED_W-1:0] elapsed_ms;
    } item_t;

    typedef struct packed {
        logic               timeout_reported;
        logic               notify;
        logic               battery_mgr_suspended;
        logic               line_level;
        logic               line_driven;
        logic               host_power_on;
        logic [STATE_W-1:0] seq_state;
    } result_t;

    localparam int unsigned ITEM_W   = $bits(item_t);
    localparam int unsigned RESULT_W = $bits(result_t);

endpackage

### rtl/core/hpds_cfg.sv
module hpds_cfg
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [hpds_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hpds_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output hpds_pkg::cfg_t                    cfg
);

    hpds_pkg::cfg_t cfg_reg;
    hpds_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                hpds_pkg::CFG_HALT_CURRENT_LIMIT:
                    cfg_next.halt_current_limit = cfg_wdata[hpds_pkg::CUR_W-1:0];
                hpds_pkg::CFG_HALT_TIMEOUT_MS:
                    cfg_next.halt_timeout_ms = cfg_wdata[hpds_pkg::TIMER_W-1:0];
                hpds_pkg::CFG_POST_HALT_DELAY_MS:
                    cfg_next.post_halt_delay_ms = cfg_wdata[hpds_pkg::TIMER_W-1:0];
                hpds_pkg::CFG_SETTLE_TIME_MS:
                    cfg_next.settle_time_ms = cfg_wdata[hpds_pkg::TIMER_W-1:0];
                hpds_pkg::CFG_NOTIFY_ENABLE:
                    cfg_next.notify_enable = cfg_wdata[0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.halt_current_limit <= hpds_pkg::RST_HALT_CURRENT_LIMIT;
            cfg_reg.halt_timeout_ms    <= hpds_pkg::RST_HALT_TIMEOUT_MS;
            cfg_reg.post_halt_delay_ms <= hpds_pkg::RST_POST_HALT_DELAY_MS;
            cfg_reg.settle_time_ms     <= hpds_pkg::RST_SETTLE_TIME_MS;
            cfg_reg.notify_enable      <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/core/hpds_in_stage.sv
module hpds_in_stage
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [hpds_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic                              advance,
    output logic                              item_valid,
    output hpds_pkg::item_t                   item
);

    logic            vld_reg;
    logic            vld_next;
    hpds_pkg::item_t item_reg;
    logic            load;

    assign s_tready = !vld_reg || advance;
    assign load     = s_tvalid && s_tready;

    always_comb
    begin
        if (load)
        begin
            vld_next = 1'b1;
        end
        else if (advance)
        begin
            vld_next = 1'b0;
        end
        else
        begin
            vld_next = vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= hpds_pkg::item_t'(s_tdata[hpds_pkg::ITEM_W-1:0]);
        end
    end

    assign item_valid = vld_reg;
    assign item       = item_reg;

endmodule

### rtl/core/hpds_fsm.sv
`include "assert_macros.svh"

module hpds_fsm
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step_en,
    input  hpds_pkg::item_t     item,
    input  hpds_pkg::cfg_t      cfg,
    output hpds_pkg::result_t   result
);

    logic [hpds_pkg::STATE_W-1:0] state_reg;
    logic [hpds_pkg::STATE_W-1:0] state_next;
    logic [hpds_pkg::TIMER_W-1:0] timer_reg;
    logic [hpds_pkg::TIMER_W-1:0] timer_next;
    logic [hpds_pkg::CUR_W-1:0]   last_cur_reg;
    logic [hpds_pkg::CUR_W-1:0]   last_cur_next;
    logic                         power_en_reg;
    logic                         power_en_next;
    logic                         line_dir_reg;
    logic                         line_dir_next;
    logic                         line_lvl_reg;
    logic                         line_lvl_next;
    logic                         bm_susp_reg;
    logic                         bm_susp_next;

    logic [hpds_pkg::TIMER_W:0]   sum;
    logic [hpds_pkg::TIMER_W-1:0] t;
    logic [hpds_pkg::STATE_W-1:0] st;
    logic [hpds_pkg::CUR_W:0]     cur_p1;
    logic [hpds_pkg::CUR_W:0]     last_p1;
    logic                         in_band;
    logic                         changed;
    logic                         tmo;

    assign sum = {1'b0, timer_reg}
               + {{(hpds_pkg::TIMER_W + 1 - hpds_pkg::ELAPSED_W){1'b0}}, item.elapsed_ms};
    assign t   = sum[hpds_pkg::TIMER_W] ? '1 : sum[hpds_pkg::TIMER_W-1:0];
    assign st  = item.soft_halt_request ? hpds_pkg::ST_SOFT_HALT : state_reg;

    assign cur_p1  = {1'b0, item.supply_current} + 1'b1;
    assign last_p1 = {1'b0, last_cur_reg} + 1'b1;
    assign in_band = (cur_p1 >= {1'b0, last_cur_reg})
                  && ({1'b0, item.supply_current} <= last_p1);

    always_comb
    begin
        state_next    = st;
        timer_next    = t;
        last_cur_next = last_cur_reg;
        power_en_next = power_en_reg;
        line_dir_next = line_dir_reg;
        line_lvl_next = line_lvl_reg;
        bm_susp_next  = bm_susp_reg;
        changed       = 1'b0;
        tmo           = 1'b0;
        if (!item.skip_step)
        begin
            unique case (st)
                hpds_pkg::ST_UP:
                begin
                    if (!item.button_low)
                    begin
                        timer_next = '0;
                    end
                    else if (t > hpds_pkg::BUTTON_HOLD_MS)
                    begin
                        line_dir_next = 1'b1;
                        line_lvl_next = 1'b0;
                        timer_next    = '0;
                        state_next    = hpds_pkg::ST_HALT;
                        changed       = 1'b1;
                    end
                end
                hpds_pkg::ST_SOFT_HALT:
                begin
                    line_dir_next = 1'b1;
                    line_lvl_next = 1'b0;
                    timer_next    = '0;
                    state_next    = hpds_pkg::ST_HALT;
                    changed       = 1'b1;
                end
                hpds_pkg::ST_HALT:
                begin
                    if (t > hpds_pkg::HALT_PULSE_MS)
                    begin
                        bm_susp_next = 1'b1;
                        timer_next   = '0;
                        state_next   = hpds_pkg::ST_CUR_CHECK;
                        changed      = 1'b1;
                    end
                end
                hpds_pkg::ST_CUR_CHECK:
                begin
                    if (t > cfg.halt_timeout_ms)
                    begin
                        state_next = hpds_pkg::ST_TIMEOUT;
                        changed    = 1'b1;
                        tmo        = 1'b1;
                    end
                    if (item.supply_current < cfg.halt_current_limit)
                    begin
                        state_next = hpds_pkg::ST_AT_HALT_CUR;
                        changed    = 1'b1;
                    end
                end
                hpds_pkg::ST_TIMEOUT:
                begin
                    state_next = hpds_pkg::ST_FAIL;
                    changed    = 1'b1;
                end
                hpds_pkg::ST_AT_HALT_CUR:
                begin
                    timer_next = '0;
                    state_next = hpds_pkg::ST_DELAY;
                    changed    = 1'b1;
                end
                hpds_pkg::ST_DELAY:
                begin
                    if (t > cfg.post_halt_delay_ms)
                    begin
                        state_next = hpds_pkg::ST_SETTLE;
                        changed    = 1'b1;
                    end
                end
                hpds_pkg::ST_SETTLE:
                begin
                    if (!in_band)
                    begin
                        last_cur_next = item.supply_current;
                        timer_next    = '0;
                    end
                    else if (t > cfg.settle_time_ms)
                    begin
                        state_next    = hpds_pkg::ST_DOWN;
                        power_en_next = 1'b0;
                        line_dir_next = 1'b0;
                        line_lvl_next = 1'b1;
                        bm_susp_next  = 1'b0;
                        changed       = 1'b1;
                    end
                end
                hpds_pkg::ST_DOWN:
                begin
                    if (!item.button_low)
                    begin
                        timer_next = '0;
                    end
                    else if (t > hpds_pkg::BUTTON_HOLD_MS)
                    begin
                        state_next = hpds_pkg::ST_RESTART;
                        changed    = 1'b1;
                    end
                end
                hpds_pkg::ST_RESTART:
                begin
                    if (item.button_low)
                    begin
                        timer_next = '0;
                    end
                    else if (t > hpds_pkg::BUTTON_HOLD_MS)
                    begin
                        state_next    = hpds_pkg::ST_RESTART_DLY;
                        power_en_next = 1'b1;
                        line_dir_next = 1'b1;
                        line_lvl_next = 1'b1;
                        changed       = 1'b1;
                    end
                end
                hpds_pkg::ST_RESTART_DLY:
                begin
                    if (t > hpds_pkg::LOCKOUT_MS)
                    begin
                        state_next    = hpds_pkg::ST_UP;
                        line_dir_next = 1'b0;
                        line_lvl_next = 1'b1;
                        changed       = 1'b1;
                    end
                end
                hpds_pkg::ST_FAIL:
                begin
                    power_en_next = 1'b0;
                    line_dir_next = 1'b1;
                    line_lvl_next = 1'b0;
                end
                default:
                begin
                    state_next = st;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= hpds_pkg::ST_UP;
            timer_reg    <= '0;
            last_cur_reg <= '0;
            power_en_reg <= 1'b1;
            line_dir_reg <= 1'b0;
            line_lvl_reg <= 1'b1;
            bm_susp_reg  <= 1'b0;
        end
        else if (step_en)
        begin
            state_reg    <= state_next;
            timer_reg    <= timer_next;
            last_cur_reg <= last_cur_next;
            power_en_reg <= power_en_next;
            line_dir_reg <= line_dir_next;
            line_lvl_reg <= line_lvl_next;
            bm_susp_reg  <= bm_susp_next;
        end
    end

    assign result.seq_state             = state_next;
    assign result.host_power_on         = power_en_next;
    assign result.line_driven           = line_dir_next;
    assign result.line_level            = line_lvl_next;
    assign result.battery_mgr_suspended = bm_susp_next;
    assign result.notify                = changed && cfg.notify_enable;
    assign result.timeout_reported      = tmo && cfg.notify_enable;

    `HPDS_ASSERT_NEXT(a_soft_to_halt,
        step_en && item.soft_halt_request && !item.skip_step,
        state_reg == hpds_pkg::ST_HALT,
        "soft halt request did not reach the halt state")

    `HPDS_ASSERT_NEXT(a_fail_holds_off,
        step_en && state_reg == hpds_pkg::ST_FAIL && !item.soft_halt_request
            && !item.skip_step,
        !power_en_reg && line_dir_reg && !line_lvl_reg && state_reg == hpds_pkg::ST_FAIL,
        "fail state released host power or shutdown line")

    `HPDS_ASSERT_NEXT(a_down_release_clears_timer,
        step_en && state_reg == hpds_pkg::ST_DOWN && !item.soft_halt_request
            && !item.skip_step && !item.button_low,
        timer_reg == '0 && state_reg == hpds_pkg::ST_DOWN,
        "released button in down state did not restart the timer")

    `HPDS_ASSERT_NOW(a_skip_no_change,
        step_en && item.skip_step,
        !result.notify && !result.timeout_reported && result.seq_state == st,
        "skipped beat changed state or reported")

endmodule

### rtl/core/host_power_down_sequencer_core.sv
// Host power-down sequencer.
// Input stream (s_tvalid/s_tready/s_tdata): one beat per evaluation tick,
// carrying elapsed time, button level, supply current sample, software halt
// request and skip flag. Output stream (m_tvalid/m_tready/m_tdata): exactly
// one result beat per input beat, in order, with the state code, pin drives
// and notification flags after that tick.
// Configuration: cfg_wr_en/cfg_index/cfg_wdata write one register per cycle;
// write only while no beat is in flight.
// Path: an input beat is taken into the input register, then the state update
// in the sequencer writes its result into the result register, which drives
// m_tvalid and m_tdata.
// Throughput: one beat per cycle while m_tready stays high; the state update
// in the sequencer sets this figure.
// Reset: host powered, shutdown line as input with pull-up, timer cleared,
// configuration at default values, both channels empty.
// Stall: when m_tready is low the result register holds its beat, the input
// register fills and then s_tready drops until the result beat is taken.
module host_power_down_sequencer_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    // [9:0] elapsed_ms, [10] button_low, [20:11] supply_current,
    // [21] soft_halt_request, [22] skip_step, [23] unused
    input  logic [hpds_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [3:0] seq_state, [4] host_power_on, [5] line_driven, [6] line_level,
    // [7] battery_mgr_suspended, [8] notify, [9] timeout_reported, [15:10] zero
    output logic [hpds_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_wr_en,
    input  logic [hpds_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hpds_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    hpds_pkg::cfg_t    cfg;
    hpds_pkg::item_t   item;
    hpds_pkg::result_t result;
    hpds_pkg::result_t res_reg;
    logic              item_valid;
    logic              advance;
    logic              step_en;
    logic              out_vld_reg;
    logic              out_vld_next;

    assign advance = !out_vld_reg || m_tready;
    assign step_en = item_valid && advance;

    hpds_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    hpds_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    hpds_fsm u_fsm
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .item    (item),
        .cfg     (cfg),
        .result  (result)
    );

    always_comb
    begin
        if (step_en)
        begin
            out_vld_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            res_reg <= result;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(hpds_pkg::OUT_DATA_W - hpds_pkg::RESULT_W){1'b0}}, res_reg};

endmodule

### tb/sv/host_power_down_sequencer_core_tb.sv
`timescale 1ns / 100ps

module host_power_down_sequencer_core_tb;

    localparam int CLK_HALF        = 6;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int DRAIN_CYCLES    = 4;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int MAX_REPORTS     = 10;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic [hpds_pkg::IN_DATA_W-1:0]  s_tdata   = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [hpds_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [hpds_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [hpds_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    always #CLK_HALF clk = ~clk;

    host_power_down_sequencer_core DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // sequencer copy
    logic [hpds_pkg::STATE_W-1:0] mdl_state    = hpds_pkg::ST_UP;
    logic [hpds_pkg::TIMER_W-1:0] mdl_timer    = '0;
    logic [10:0]                  mdl_last_cur = '0;
    bit                           mdl_pwr      = 1'b1;
    bit                           mdl_drv      = 1'b0;
    bit                           mdl_lvl      = 1'b1;
    bit                           mdl_sus      = 1'b0;

    logic [hpds_pkg::CUR_W-1:0]   cfg_limit    = hpds_pkg::RST_HALT_CURRENT_LIMIT;
    logic [hpds_pkg::TIMER_W-1:0] cfg_timeout  = hpds_pkg::RST_HALT_TIMEOUT_MS;
    logic [hpds_pkg::TIMER_W-1:0] cfg_delay    = hpds_pkg::RST_POST_HALT_DELAY_MS;
    logic [hpds_pkg::TIMER_W-1:0] cfg_settle   = hpds_pkg::RST_SETTLE_TIME_MS;
    bit                           cfg_notify   = 1'b0;

    hpds_pkg::result_t tick_q [$];
    int                mismatches     = 0;
    int                send_idle_pct  = 0;
    int                recv_idle_pct  = 0;
    bit                pressure_armed = 1'b0;
    bit                hold_done      = 1'b0;
    int                hold_left      = 0;

    hpds_pkg::item_t   dir_items [$];
    bit                dir_typed [$];
    hpds_pkg::result_t dir_res   [$];

    hpds_pkg::result_t mon_got;
    hpds_pkg::result_t mon_want;

    function automatic hpds_pkg::result_t mk_res(input logic [hpds_pkg::STATE_W-1:0] st,
                                                 input bit pwr, input bit drv, input bit lvl,
                                                 input bit sus, input bit ntf, input bit tmo);
        hpds_pkg::result_t r;
        r.seq_state             = st;
        r.host_power_on         = pwr;
        r.line_driven           = drv;
        r.line_level            = lvl;
        r.battery_mgr_suspended = sus;
        r.notify                = ntf;
        r.timeout_reported      = tmo;
        return r;
    endfunction

    function automatic hpds_pkg::item_t mk_item(input int el, input bit btn, input int cur,
                                                input bit soft_req, input bit skip);
        hpds_pkg::item_t it;
        it.elapsed_ms        = hpds_pkg::ELAPSED_W'(el);
        it.button_low        = btn;
        it.supply_current    = hpds_pkg::CUR_W'(cur);
        it.soft_halt_request = soft_req;
        it.skip_step         = skip;
        return it;
    endfunction

    function automatic hpds_pkg::result_t step_sequencer(input hpds_pkg::item_t it);
        logic [hpds_pkg::TIMER_W:0]   sum;
        logic [hpds_pkg::TIMER_W-1:0] t;
        bit                           changed;
        bit                           tmo;
        int                           c;
        int                           l;
        hpds_pkg::result_t            r;
        changed = 1'b0;
        tmo     = 1'b0;
        sum = {1'b0, mdl_timer} + (hpds_pkg::TIMER_W + 1)'(it.elapsed_ms);
        mdl_timer = sum[hpds_pkg::TIMER_W] ? {hpds_pkg::TIMER_W{1'b1}}
                                           : sum[hpds_pkg::TIMER_W-1:0];
        if (it.soft_halt_request)
            mdl_state = hpds_pkg::ST_SOFT_HALT;
        if (!it.skip_step)
        begin
            t = mdl_timer;
            case (mdl_state)
                hpds_pkg::ST_UP:
                begin
                    if (it.button_low)
                    begin
                        if (t > hpds_pkg::BUTTON_HOLD_MS)
                        begin
                            mdl_drv = 1'b1;
                            mdl_lvl = 1'b0;
                            mdl_timer = '0;
                            mdl_state = hpds_pkg::ST_HALT;
                            changed = 1'b1;
                        end
                    end
                    else
                        mdl_timer = '0;
                end
                hpds_pkg::ST_SOFT_HALT:
                begin
                    mdl_drv = 1'b1;
                    mdl_lvl = 1'b0;
                    mdl_timer = '0;
                    mdl_state = hpds_pkg::ST_HALT;
                    changed = 1'b1;
                end
                hpds_pkg::ST_HALT:
                begin
                    if (t > hpds_pkg::HALT_PULSE_MS)
                    begin
                        mdl_sus = 1'b1;
                        mdl_timer = '0;
                        mdl_state = hpds_pkg::ST_CUR_CHECK;
                        changed = 1'b1;
                    end
                end
                hpds_pkg::ST_CUR_CHECK:
                begin
                    if (t > cfg_timeout)
                    begin
                        mdl_state = hpds_pkg::ST_TIMEOUT;
                        changed = 1'b1;
                        tmo = 1'b1;
                    end
                    if (it.supply_current < cfg_limit)
                    begin
                        mdl_state = hpds_pkg::ST_AT_HALT_CUR;
                        changed = 1'b1;
                    end
                end
                hpds_pkg::ST_TIMEOUT:
                begin
                    mdl_state = hpds_pkg::ST_FAIL;
                    changed = 1'b1;
                end
                hpds_pkg::ST_AT_HALT_CUR:
                begin
                    mdl_timer = '0;
                    mdl_state = hpds_pkg::ST_DELAY;
                    changed = 1'b1;
                end
                hpds_pkg::ST_DELAY:
                begin
                    if (t > cfg_delay)
                    begin
                        mdl_state = hpds_pkg::ST_SETTLE;
                        changed = 1'b1;
                    end
                end
                hpds_pkg::ST_SETTLE:
                begin
                    c = int'(it.supply_current);
                    l = int'(mdl_last_cur);
                    if (c >= l - 1 && c <= l + 1)
                    begin
                        if (t > cfg_settle)
                        begin
                            mdl_state = hpds_pkg::ST_DOWN;
                            mdl_pwr = 1'b0;
                            mdl_drv = 1'b0;
                            mdl_lvl = 1'b1;
                            mdl_sus = 1'b0;
                            changed = 1'b1;
                        end
                    end
                    else
                    begin
                        mdl_last_cur = 11'(it.supply_current);
                        mdl_timer = '0;
                    end
                end
                hpds_pkg::ST_DOWN:
                begin
                    if (it.button_low)
                    begin
                        if (t > hpds_pkg::BUTTON_HOLD_MS)
                        begin
                            mdl_state = hpds_pkg::ST_RESTART;
                            changed = 1'b1;
                        end
                    end
                    else
                        mdl_timer = '0;
                end
                hpds_pkg::ST_RESTART:
                begin
                    if (!it.button_low)
                    begin
                        if (t > hpds_pkg::BUTTON_HOLD_MS)
                        begin
                            mdl_state = hpds_pkg::ST_RESTART_DLY;
                            mdl_pwr = 1'b1;
                            mdl_drv = 1'b1;
                            mdl_lvl = 1'b1;
                            changed = 1'b1;
                        end
                    end
                    else
                        mdl_timer = '0;
                end
                hpds_pkg::ST_RESTART_DLY:
                begin
                    if (t > hpds_pkg::LOCKOUT_MS)
                    begin
                        mdl_state = hpds_pkg::ST_UP;
                        mdl_drv = 1'b0;
                        mdl_lvl = 1'b1;
                        changed = 1'b1;
                    end
                end
                hpds_pkg::ST_FAIL:
                begin
                    mdl_pwr = 1'b0;
                    mdl_drv = 1'b1;
                    mdl_lvl = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
        r = mk_res(mdl_state, mdl_pwr, mdl_drv, mdl_lvl, mdl_sus,
                   changed && cfg_notify, tmo && cfg_notify);
        return r;
    endfunction

    task automatic add_row(input hpds_pkg::item_t it, input bit typed,
                           input hpds_pkg::result_t res);
        dir_items.push_back(it);
        dir_typed.push_back(typed);
        dir_res.push_back(res);
    endtask

    task automatic write_config(input logic [hpds_pkg::CUR_W-1:0] limit,
                                input logic [hpds_pkg::TIMER_W-1:0] tmo_ms,
                                input logic [hpds_pkg::TIMER_W-1:0] dly,
                                input logic [hpds_pkg::TIMER_W-1:0] settle,
                                input bit ntf);
        logic [hpds_pkg::CFG_IDX_W-1:0]  idx [5];
        logic [hpds_pkg::CFG_DATA_W-1:0] val [5];
        idx = '{hpds_pkg::CFG_HALT_CURRENT_LIMIT, hpds_pkg::CFG_HALT_TIMEOUT_MS,
                hpds_pkg::CFG_POST_HALT_DELAY_MS, hpds_pkg::CFG_SETTLE_TIME_MS,
                hpds_pkg::CFG_NOTIFY_ENABLE};
        val = '{hpds_pkg::CFG_DATA_W'(limit), tmo_ms, dly, settle,
                hpds_pkg::CFG_DATA_W'(ntf)};
        for (int i = 0; i < 5; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= val[i];
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
        cfg_limit   = limit;
        cfg_timeout = tmo_ms;
        cfg_delay   = dly;
        cfg_settle  = settle;
        cfg_notify  = ntf;
    endtask

    task automatic send_tick(input hpds_pkg::item_t it, input bit typed,
                             input hpds_pkg::result_t typed_res);
        hpds_pkg::result_t pred;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= hpds_pkg::IN_DATA_W'(it);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pred = step_sequencer(it);
        tick_q.push_back(typed ? typed_res : pred);
    endtask

    task automatic drain_ticks();
        s_tvalid <= 1'b0;
        while (tick_q.size() != 0)
            @(posedge clk);
    endtask

    // bias each tick toward the path out of the current state
    task automatic run_ticks(input int n);
        hpds_pkg::item_t it;
        int              pick;
        int              cur;
        bit              btn;
        int              soft_pct;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 15)
                it.elapsed_ms = '0;
            else if (pick < 25)
                it.elapsed_ms = '1;
            else if (pick < 70)
                it.elapsed_ms = hpds_pkg::ELAPSED_W'($urandom_range(1023, 600));
            else
                it.elapsed_ms = hpds_pkg::ELAPSED_W'($urandom_range(1023));

            case (mdl_state)
                hpds_pkg::ST_UP, hpds_pkg::ST_DOWN: btn = ($urandom_range(99) < 85);
                hpds_pkg::ST_RESTART:               btn = ($urandom_range(99) < 20);
                default:                            btn = $urandom_range(1);
            endcase
            it.button_low = btn;

            pick = $urandom_range(99);
            if (pick < 10)
                cur = 0;
            else if (pick < 20)
                cur = 1023;
            else
                cur = $urandom_range(1023);
            if (mdl_state == hpds_pkg::ST_CUR_CHECK && cfg_limit != 0
                && $urandom_range(99) < 35)
                cur = $urandom_range(int'(cfg_limit) - 1);
            if (mdl_state == hpds_pkg::ST_SETTLE && $urandom_range(99) < 80)
            begin
                cur = int'(mdl_last_cur) + int'($urandom_range(2)) - 1;
                if (cur < 0)
                    cur = 0;
                if (cur > 1023)
                    cur = 1023;
            end
            it.supply_current = hpds_pkg::CUR_W'(cur);

            case (mdl_state)
                hpds_pkg::ST_FAIL: soft_pct = 20;
                hpds_pkg::ST_UP:   soft_pct = 4;
                default:           soft_pct = 1;
            endcase
            it.soft_halt_request = ($urandom_range(99) < soft_pct);
            it.skip_step = ($urandom_range(99) < 5);
            send_tick(it, 1'b0, hpds_pkg::result_t'('0));
        end
    endtask

    task automatic note_mismatch(input string what, input hpds_pkg::result_t want,
                                 input hpds_pkg::result_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display({"%s: expected st=%0d pwr=%b drv=%b lvl=%b bms=%b ntf=%b tmo=%b,",
                      " got st=%0d pwr=%b drv=%b lvl=%b bms=%b ntf=%b tmo=%b"},
                     what, want.seq_state, want.host_power_on, want.line_driven,
                     want.line_level, want.battery_mgr_suspended, want.notify,
                     want.timeout_reported, got.seq_state, got.host_power_on,
                     got.line_driven, got.line_level, got.battery_mgr_suspended,
                     got.notify, got.timeout_reported);
    endtask

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            mon_got = hpds_pkg::result_t'(m_tdata[hpds_pkg::RESULT_W-1:0]);
            if (tick_q.size() == 0)
                note_mismatch("result beat with nothing pending",
                              hpds_pkg::result_t'('0), mon_got);
            else
            begin
                mon_want = tick_q.pop_front();
                if (mon_got.seq_state != mon_want.seq_state
                    || mon_got.host_power_on != mon_want.host_power_on
                    || mon_got.line_driven != mon_want.line_driven
                    || mon_got.line_level != mon_want.line_level
                    || mon_got.battery_mgr_suspended != mon_want.battery_mgr_suspended
                    || mon_got.notify != mon_want.notify
                    || mon_got.timeout_reported != mon_want.timeout_reported)
                    note_mismatch("result mismatch", mon_want, mon_got);
            end
        end
    end

    // hold off once for a long stretch so the input side backs up
    always @(posedge clk)
    begin
        if (pressure_armed && !hold_done)
        begin
            hold_left = HOLD_OFF_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("host_power_down_sequencer_core regression: fail");
        $finish;
    end

    initial
    begin
        add_row(mk_item(0, 0, 0, 0, 0), 1, mk_res(hpds_pkg::ST_UP, 1, 0, 1, 0, 0, 0));
        add_row(mk_item(1023, 1, 1023, 0, 0), 0, hpds_pkg::result_t'('0));
        add_row(mk_item(1023, 1, 512, 0, 0), 1,
                mk_res(hpds_pkg::ST_HALT, 1, 1, 0, 0, 1, 0));
        add_row(mk_item(1023, 0, 0, 0, 1), 0, hpds_pkg::result_t'('0));
        add_row(mk_item(0, 0, 0, 0, 0), 0, hpds_pkg::result_t'('0));
        add_row(mk_item(600, 0, 500, 0, 0), 0, hpds_pkg::result_t'('0));
        add_row(mk_item(1023, 0, 50, 0, 0), 1,
                mk_res(hpds_pkg::ST_AT_HALT_CUR, 1, 1, 0, 1, 1, 1));
        add_row(mk_item(0, 0, 0, 0, 0), 0, hpds_pkg::result_t'('0));
        add_row(mk_item(301, 0, 0, 0, 0), 0, hpds_pkg::result_t'('0));
        add_row(mk_item(0, 0, 700, 0, 0), 0, hpds_pkg::result_t'('0));
        add_row(mk_item(200, 0, 701, 0, 0), 0, hpds_pkg::result_t'('0));
        add_row(mk_item(200, 0, 699, 0, 0), 0, hpds_pkg::result_t'('0));
        add_row(mk_item(1023, 0, 1023, 0, 0), 0, hpds_pkg::result_t'('0));
        add_row(mk_item(1023, 1, 0, 0, 0), 0, hpds_pkg::result_t'('0));
        add_row(mk_item(1023, 1, 341, 0, 0), 0, hpds_pkg::result_t'('0));
        add_row(mk_item(1023, 1, 682, 0, 0), 0, hpds_pkg::result_t'('0));
        add_row(mk_item(1023, 0, 0, 0, 0), 0, hpds_pkg::result_t'('0));
        add_row(mk_item(1023, 0, 0, 0, 0), 0, hpds_pkg::result_t'('0));
        add_row(mk_item(5, 0, 0, 1, 0), 0, hpds_pkg::result_t'('0));
        add_row(mk_item(0, 0, 0, 1, 1), 0, hpds_pkg::result_t'('0));
        add_row(mk_item(0, 0, 0, 0, 0), 0, hpds_pkg::result_t'('0));
        add_row(mk_item(201, 0, 0, 0, 0), 0, hpds_pkg::result_t'('0));
        add_row(mk_item(1001, 0, 1023, 0, 0), 1,
                mk_res(hpds_pkg::ST_TIMEOUT, 1, 1, 0, 1, 1, 1));
        add_row(mk_item(0, 0, 0, 0, 0), 0, hpds_pkg::result_t'('0));
        add_row(mk_item(0, 0, 0, 0, 0), 1, mk_res(hpds_pkg::ST_FAIL, 0, 1, 0, 1, 0, 0));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 13;
        recv_idle_pct = 57;
        write_config(10'd100, 32'd1000, 32'd300, 32'd300, 1'b1);
        for (int i = 0; i < dir_items.size(); i++)
            send_tick(dir_items[i], dir_typed[i], dir_res[i]);
        drain_ticks();

        write_config(10'd100, 32'd20000, 32'd1000, 32'd1000, 1'b1);
        run_ticks(450);
        drain_ticks();

        send_idle_pct = 57;
        recv_idle_pct = 13;
        write_config(10'd1023, 32'd0, 32'd0, 32'd0, 1'b0);
        run_ticks(400);
        drain_ticks();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_config(10'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        run_ticks(100);
        drain_ticks();

        write_config(hpds_pkg::CUR_W'($urandom_range(1023)), $urandom_range(8000),
                     $urandom_range(3000), $urandom_range(3000), 1'b1);
        pressure_armed = 1'b1;
        run_ticks(350);
        drain_ticks();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tick_q.size() != 0)
        begin
            mismatches += tick_q.size();
            $display("%0d expected results never arrived", tick_q.size());
        end
        if (mismatches == 0)
            $display("host_power_down_sequencer_core regression: pass");
        else
            $display("host_power_down_sequencer_core regression: fail");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/hpds_pkg.sv
rtl/core/hpds_cfg.sv
rtl/core/hpds_in_stage.sv
rtl/core/hpds_fsm.sv
rtl/core/host_power_down_sequencer_core.sv
tb/sv/host_power_down_sequencer_core_tb.sv
